// ===== rtl/orsm_pkg.sv =====
// shared types, constants and codes for the surround register mirror
package orsm_pkg;

    localparam int REG_W      = 8;
    localparam int ADDR_OUT_W = 9;
    localparam int DIV_W      = 10;
    localparam int FNUM_W     = 10;
    localparam int QUO_W      = 10;
    localparam int DEN_W      = 11;
    localparam int NUM_W      = DEN_W + QUO_W;
    localparam int PROD_W     = 20;
    localparam int FREQ_DEPTH = 32;
    localparam int SLOT_W     = $clog2(FREQ_DEPTH);

    localparam logic [DIV_W-1:0]  DETUNE_RESET = 10'd384;
    localparam logic [FNUM_W-1:0] FNUM_MAX     = 10'd1023;
    localparam logic [FNUM_W-1:0] EDGE_LIMIT   = 10'd32;
    localparam logic [FNUM_W-1:0] UPPER_EDGE   = FNUM_MAX - EDGE_LIMIT;

    localparam logic [REG_W-1:0] PERC_REG   = 8'hBD;
    localparam logic [REG_W-1:0] TEST_REG_A = 8'h04;
    localparam logic [REG_W-1:0] TEST_REG_B = 8'h05;
    localparam logic [3:0]       GRP_A      = 4'hA;
    localparam logic [3:0]       GRP_B      = 4'hB;
    localparam logic [3:0]       GRP_C      = 4'hC;
    localparam logic [3:0]       LOW_CH_MAX = 4'd5;
    localparam logic [3:0]       USED_CH_MAX = 4'd8;
    localparam logic [REG_W-1:0] PAN_LEFT   = 8'h10;
    localparam logic [REG_W-1:0] PAN_RIGHT  = 8'h20;
    localparam logic [REG_W-1:0] PAN_BOTH   = 8'h30;
    localparam logic [REG_W-1:0] PARTNER_FLIP = 8'h10;
    localparam int               PERC_BIT   = 5;
    localparam int               KEY_ON_BIT = 5;

    typedef struct packed {
        logic [REG_W-1:0] reg_addr;
        logic [REG_W-1:0] wr_data;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_OUT_W-1:0] out_addr;
        logic [REG_W-1:0]      out_data;
        logic                  last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_WR_ORIG,
        ST_RD_HI,
        ST_RD_LO,
        ST_MUL,
        ST_CLASS,
        ST_DIV,
        ST_UPD,
        ST_PART,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        EMIT_FIRST,
        EMIT_SECOND,
        EMIT_PARTNER,
        EMIT_FINAL
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      load_out;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      wr_orig;
        logic      rd_hi;
        logic      rd_lo;
        logic      mul;
        logic      classify;
        logic      upd;
        logic      wr_part;
    } ctrl_cmd_t;

    typedef struct packed {
        logic second;
        logic detune;
        logic used;
        logic need_div;
        logic div_done;
        logic part_needed;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ===== rtl/orsm_ram.sv =====
// generic single write port ram with registered read
module orsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/orsm_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit
module orsm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [orsm_pkg::NUM_W-1:0]   num,
    input  logic [orsm_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [orsm_pkg::QUO_W-1:0]   quo
);

    localparam int QW = orsm_pkg::QUO_W;
    localparam int DW = orsm_pkg::DEN_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] sh_reg;
    logic [QW-1:0] quo_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial    = {rem_reg, sh_reg[QW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // upper part of the dividend is already below the divisor
            rem_reg <= num[orsm_pkg::NUM_W-1:QW];
            sh_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// ===== rtl/orsm_ctrl.sv =====
// sequencer for decode, frequency store access, detune and chip writes
module orsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  orsm_pkg::ctrl_stat_t stat,
    output orsm_pkg::ctrl_cmd_t  cmd
);

    orsm_pkg::state_t state_reg;
    orsm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= orsm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = orsm_pkg::EMIT_FIRST;
        in_stall     = 1'b1;

        unique case (state_reg)
            orsm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = orsm_pkg::ST_FIRST;
                end
            end
            orsm_pkg::ST_FIRST:
            begin
                cmd.emit_sel  = orsm_pkg::EMIT_FIRST;
                cmd.emit_last = !(stat.second || stat.detune);
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.second)
                    begin
                        state_next = orsm_pkg::ST_SECOND;
                    end
                    else if (stat.detune)
                    begin
                        state_next = orsm_pkg::ST_WR_ORIG;
                    end
                    else
                    begin
                        state_next = orsm_pkg::ST_IDLE;
                    end
                end
            end
            orsm_pkg::ST_SECOND:
            begin
                cmd.emit_sel  = orsm_pkg::EMIT_SECOND;
                cmd.emit_last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = orsm_pkg::ST_IDLE;
                end
            end
            orsm_pkg::ST_WR_ORIG:
            begin
                cmd.wr_orig = 1'b1;
                // unused channels never get a detuned value, skip the math
                state_next  = stat.used ? orsm_pkg::ST_RD_HI : orsm_pkg::ST_FINAL;
            end
            orsm_pkg::ST_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = orsm_pkg::ST_RD_LO;
            end
            orsm_pkg::ST_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = orsm_pkg::ST_MUL;
            end
            orsm_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = orsm_pkg::ST_CLASS;
            end
            orsm_pkg::ST_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = stat.need_div ? orsm_pkg::ST_DIV : orsm_pkg::ST_UPD;
            end
            orsm_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = orsm_pkg::ST_UPD;
                end
            end
            orsm_pkg::ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = stat.part_needed ? orsm_pkg::ST_PART : orsm_pkg::ST_FINAL;
            end
            orsm_pkg::ST_PART:
            begin
                cmd.emit_sel = orsm_pkg::EMIT_PARTNER;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.wr_part  = 1'b1;
                    state_next   = orsm_pkg::ST_FINAL;
                end
            end
            orsm_pkg::ST_FINAL:
            begin
                cmd.emit_sel  = orsm_pkg::EMIT_FINAL;
                cmd.emit_last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = orsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = orsm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/orsm_dp.sv =====
// datapath: request decode, frequency stores, detune arithmetic, output register
module orsm_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  orsm_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output orsm_pkg::out_item_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [orsm_pkg::DIV_W-1:0]        cfg_data,
    input  orsm_pkg::ctrl_cmd_t               cmd,
    output orsm_pkg::ctrl_stat_t              stat
);

    localparam int RW = orsm_pkg::REG_W;
    localparam int SW = orsm_pkg::SLOT_W;
    localparam int FW = orsm_pkg::FNUM_W;
    localparam int PW = orsm_pkg::PROD_W;
    localparam int DV = orsm_pkg::DIV_W;

    logic [RW-1:0]   addr_reg;
    logic [RW-1:0]   data_reg;
    logic            perc_reg;
    logic [DV-1:0]   det_div_reg;
    logic [RW-1:0]   hi_reg;
    logic [FW-1:0]   fnum_reg;
    logic [PW-1:0]   p_reg;
    logic            keep_reg;
    logic [2:0]      nblock_reg;
    logic [RW-1:0]   sval_reg;
    logic [RW-1:0]   pval_reg;
    logic [orsm_pkg::FREQ_DEPTH-1:0] orig_valid_reg;
    logic [orsm_pkg::FREQ_DEPTH-1:0] det_valid_reg;
    logic            orig_rv_reg;
    logic            det_rv_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    orsm_pkg::out_item_t out_item_reg;
    orsm_pkg::out_item_t out_item_next;

    // request decode
    logic [3:0]  grp;
    logic [3:0]  ch;
    logic        low_ch;
    logic        is_c;
    logic        is_ab;
    logic        pan_two;
    logic        mirror;
    logic [SW-1:0] slot;
    logic [SW-1:0] pslot;

    assign grp     = addr_reg[7:4];
    assign ch      = addr_reg[3:0];
    assign low_ch  = ch <= orsm_pkg::LOW_CH_MAX;
    assign is_c    = grp == orsm_pkg::GRP_C;
    assign is_ab   = (grp == orsm_pkg::GRP_A) || (grp == orsm_pkg::GRP_B);
    assign pan_two = low_ch || !perc_reg;
    assign mirror  = !is_c && !is_ab
                     && (addr_reg != orsm_pkg::TEST_REG_A)
                     && (addr_reg != orsm_pkg::TEST_REG_B)
                     && (!perc_reg || !grp[0]);
    assign slot    = addr_reg[SW-1:0];
    assign pslot   = {~addr_reg[SW-1], addr_reg[SW-2:0]};

    // frequency stores
    logic          orig_re;
    logic [SW-1:0] orig_raddr;
    logic [RW-1:0] orig_rdata;
    logic [RW-1:0] orig_val;
    logic          det_we;
    logic [SW-1:0] det_waddr;
    logic [RW-1:0] det_wdata;
    logic [RW-1:0] det_rdata;
    logic [RW-1:0] det_cmp;

    assign orig_re    = cmd.rd_hi || cmd.rd_lo;
    assign orig_raddr = {cmd.rd_hi, ch};
    assign orig_val   = orig_rv_reg ? orig_rdata : '0;
    assign det_cmp    = det_rv_reg ? det_rdata : '0;

    orsm_ram #(
        .WIDTH (RW),
        .DEPTH (orsm_pkg::FREQ_DEPTH)
    ) u_orig_ram (
        .clk   (clk),
        .we    (cmd.wr_orig),
        .waddr (slot),
        .wdata (data_reg),
        .re    (orig_re),
        .raddr (orig_raddr),
        .rdata (orig_rdata)
    );

    orsm_ram #(
        .WIDTH (RW),
        .DEPTH (orsm_pkg::FREQ_DEPTH)
    ) u_det_ram (
        .clk   (clk),
        .we    (det_we),
        .waddr (det_waddr),
        .wdata (det_wdata),
        .re    (cmd.rd_hi),
        .raddr (pslot),
        .rdata (det_rdata)
    );

    // detune arithmetic
    logic [FW-1:0]   fnum;
    logic [DV:0]     dp1;
    logic [PW:0]     prod;
    logic [PW-1:0]   up_lim;
    logic [PW-1:0]   lo_lim;
    logic [2:0]      block;
    logic            keep_c;
    logic [2:0]      nblock_c;
    logic [orsm_pkg::NUM_W-1:0] num_c;
    logic [orsm_pkg::DEN_W-1:0] den_c;
    logic            div_start;
    logic            div_done;
    logic [orsm_pkg::QUO_W-1:0] quo;

    assign fnum   = {hi_reg[1:0], orig_val};
    assign dp1    = {1'b0, det_div_reg} + (DV+1)'(1);
    assign prod   = (PW+1)'(fnum) * (PW+1)'(dp1);
    assign up_lim = PW'(orsm_pkg::UPPER_EDGE) * PW'(det_div_reg);
    assign lo_lim = PW'(orsm_pkg::EDGE_LIMIT) * PW'(det_div_reg);
    assign block  = hi_reg[4:2];

    always_comb
    begin
        keep_c   = 1'b1;
        nblock_c = block;
        num_c    = orsm_pkg::NUM_W'(p_reg);
        den_c    = {1'b0, det_div_reg};
        if (det_div_reg != '0)
        begin
            if (p_reg > up_lim)
            begin
                // near the top: one octave up, half the ratio
                if (block != 3'd7)
                begin
                    keep_c   = 1'b0;
                    nblock_c = block + 3'd1;
                    den_c    = {det_div_reg, 1'b0};
                end
            end
            else if (p_reg < lo_lim)
            begin
                if (block != 3'd0)
                begin
                    keep_c   = 1'b0;
                    nblock_c = block - 3'd1;
                    num_c    = orsm_pkg::NUM_W'({p_reg, 1'b0});
                end
            end
            else
            begin
                keep_c = 1'b0;
            end
        end
    end

    assign div_start = cmd.classify && !keep_c;

    orsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_c),
        .den   (den_c),
        .done  (div_done),
        .quo   (quo)
    );

    // new frequency register values
    logic [FW-1:0] nfnum;
    logic          is_b;
    logic [RW-1:0] sval_next;
    logic [RW-1:0] pval_next;
    logic          pflag;

    assign nfnum = keep_reg ? fnum_reg : quo;
    assign is_b  = addr_reg[4];

    always_comb
    begin
        if (is_b)
        begin
            sval_next = {data_reg[7:5], nblock_reg, nfnum[9:8]};
            pval_next = nfnum[7:0];
            pflag     = det_cmp != pval_next;
        end
        else
        begin
            sval_next = nfnum[7:0];
            pval_next = {hi_reg[7:5], nblock_reg, nfnum[9:8]};
            pflag     = pval_next[orsm_pkg::KEY_ON_BIT] && (det_cmp != pval_next);
        end
    end

    assign det_we    = cmd.upd || cmd.wr_part;
    assign det_waddr = cmd.upd ? slot : pslot;
    assign det_wdata = cmd.upd ? sval_next : pval_reg;

    // output selection
    always_comb
    begin
        out_item_next.last = cmd.emit_last;
        unique case (cmd.emit_sel)
            orsm_pkg::EMIT_FIRST:
            begin
                out_item_next.out_addr = {1'b0, addr_reg};
                if (is_c)
                begin
                    out_item_next.out_data = data_reg | (pan_two ? orsm_pkg::PAN_LEFT
                                                                 : orsm_pkg::PAN_BOTH);
                end
                else
                begin
                    out_item_next.out_data = data_reg;
                end
            end
            orsm_pkg::EMIT_SECOND:
            begin
                out_item_next.out_addr = {1'b1, addr_reg};
                out_item_next.out_data = is_c ? (data_reg | orsm_pkg::PAN_RIGHT) : data_reg;
            end
            orsm_pkg::EMIT_PARTNER:
            begin
                out_item_next.out_addr = {1'b1, addr_reg ^ orsm_pkg::PARTNER_FLIP};
                out_item_next.out_data = pval_reg;
            end
            orsm_pkg::EMIT_FINAL:
            begin
                out_item_next.out_addr = {1'b1, addr_reg};
                out_item_next.out_data = (ch <= orsm_pkg::USED_CH_MAX) ? sval_reg : '0;
            end
            default:
            begin
                out_item_next.out_addr = {1'b0, addr_reg};
                out_item_next.out_data = data_reg;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perc_reg       <= 1'b0;
            det_div_reg    <= orsm_pkg::DETUNE_RESET;
            orig_valid_reg <= '0;
            det_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                det_div_reg <= cfg_data;
            end
            if (cmd.load_out && (cmd.emit_sel == orsm_pkg::EMIT_FIRST)
                && (addr_reg == orsm_pkg::PERC_REG))
            begin
                perc_reg <= data_reg[orsm_pkg::PERC_BIT];
            end
            if (cmd.wr_orig)
            begin
                orig_valid_reg[slot] <= 1'b1;
            end
            if (det_we)
            begin
                det_valid_reg[det_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= in_item.reg_addr;
            data_reg <= in_item.wr_data;
        end
        if (orig_re)
        begin
            orig_rv_reg <= orig_valid_reg[orig_raddr];
        end
        if (cmd.rd_hi)
        begin
            det_rv_reg <= det_valid_reg[pslot];
        end
        if (cmd.rd_lo)
        begin
            hi_reg <= orig_val;
        end
        if (cmd.mul)
        begin
            fnum_reg <= fnum;
            p_reg    <= prod[PW-1:0];
        end
        if (cmd.classify)
        begin
            keep_reg   <= keep_c;
            nblock_reg <= nblock_c;
        end
        if (cmd.upd)
        begin
            sval_reg <= sval_next;
            pval_reg <= pval_next;
        end
        if (cmd.load_out)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    assign stat.second      = is_c ? pan_two : mirror;
    assign stat.detune      = is_ab && (addr_reg != orsm_pkg::PERC_REG) && pan_two;
    assign stat.used        = ch <= orsm_pkg::USED_CH_MAX;
    assign stat.need_div    = !keep_c;
    assign stat.div_done    = div_done;
    assign stat.part_needed = pflag;
    assign stat.out_free    = !out_valid_reg || !out_stall;

endmodule

// ===== rtl/opl_register_surround_mirror.sv =====
// top level of the surround register mirror
//
// Each request on the input channel carries one player register write
// (reg_addr, wr_data) and turns into one to three chip writes on the output
// channel (out_addr with bit 8 as bank select, out_data, last on the final one).
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low. The block takes one request at a time and raises in_stall
// until every write of the current request has been loaded into the output
// register.
// Sequence from accept to next accept: a panned or mirrored request loads its
// writes into the output register; a frequency request on an unused channel
// skips the math, otherwise it goes through the store write, two store reads,
// one multiply, a classify step, the restoring divider when the note is not
// kept, the update and the block-partner write when one is needed.
// The output register holds a write while out_stall is high; the sequencer
// simply waits, so a stalled receiver stretches the request by that much.
// Reset clears the percussion flag and marks both frequency stores as all
// zero; the detune divisor returns to 384. The divisor port is always ready
// and must only be written while no request is in flight.
module opl_register_surround_mirror (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  orsm_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output orsm_pkg::out_item_t           out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [orsm_pkg::DIV_W-1:0]    cfg_data
);

    orsm_pkg::ctrl_cmd_t  cmd;
    orsm_pkg::ctrl_stat_t stat;

    orsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    orsm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
